// ===== rtl/core/rfm_pkg.sv =====
// Shared types, codes and widths of the reference frame manager.
package rfm_pkg;

  localparam int POOL_SLOTS_DEF = 16;
  localparam int MAX_REFS_DEF   = 16;

  localparam int FN_W    = 16;
  localparam int POC_W   = 32;
  localparam int PN_W    = 17;
  localparam int RTP_W   = 64;
  localparam int SIDX_W  = 6;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 136;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_MAX_FN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REFS    = 1'd1;

  localparam logic [1:0] REQ_SLICE   = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [1:0] KIND_SLICE = 2'd0;
  localparam logic [1:0] KIND_LIST  = 2'd1;
  localparam logic [1:0] KIND_ACQ   = 2'd2;
  localparam logic [1:0] KIND_REL   = 2'd3;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT    = 2'd1;
  localparam logic [1:0] STAT_NONE_READY = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE, OP_POC, OP_FIND, OP_PICNUM, OP_HDR, OP_NOSLOT, OP_SCAN, OP_LIST,
    OP_FINISH, OP_EVSCAN, OP_EVICT, OP_INSERT, OP_ACQ_RD, OP_ACQ, OP_REL
  } dp_op_t;

  typedef struct packed {
    logic found;
    logic p_refs;
    logic scan_end;
    logic list_end;
    logic ref_pic;
    logic need_evict;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/h264_ref_frame_manager_top.sv =====
// Frame-slot pool and sliding-window reference manager of an H.264 decoder.
// One request is handled at a time. A decode-slice word runs the POC, slot
// search, picture-number and header steps, plus, for a P slice with references,
// the list0 sort (one store entry compared per cycle by the single scan unit),
// plus a sliding-window eviction when a reference picture fills the configured window.
// Acquire first reads the stamp memory; release needs no memory read. The next
// word is taken while the last result still waits in the output register.
// Results of a request appear in order, the last one marked by tlast.
module h264_ref_frame_manager_top import rfm_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int MAX_REFS   = MAX_REFS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // fnum[15:0], is_idr[16], ref_idc[18:17], is_p_slice[19],
  // stamp[83:20], slot_index[89:84]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[1:0], slot[5:2], fnum_out[21:6], pic_order[53:22],
  // pic_number[70:54], rtp_out[134:71]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // result_kind[1:0]
  output logic [1:0]            m_tuser,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic       s_accept;
  dp_op_t     op;
  dp_status_t st;
  logic [1:0]        o_status;
  logic [SLOT_W-1:0] o_slot;
  logic [FN_W-1:0]   o_fn;
  logic [POC_W-1:0]  o_poc;
  logic [PN_W-1:0]   o_pn;
  logic [RTP_W-1:0]  o_rtp;

  assign s_accept = s_tvalid && s_tready;
  assign m_tdata = {1'b0, o_rtp, o_pn, o_poc, o_fn, o_slot, o_status};

  rfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (s_accept),
    .in_req    (s_tuser),
    .st        (st),
    .in_ready  (s_tready),
    .op        (op)
  );

  rfm_datapath #(
    .POOL_SLOTS (POOL_SLOTS),
    .MAX_REFS   (MAX_REFS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_accept (s_accept),
    .in_fn     (s_tdata[15:0]),
    .in_idr    (s_tdata[16]),
    .in_refidc (s_tdata[18:17]),
    .in_p      (s_tdata[19]),
    .in_rtp    (s_tdata[83:20]),
    .in_sidx   (s_tdata[89:84]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .o_kind    (m_tuser),
    .o_status  (o_status),
    .o_slot    (o_slot),
    .o_fn      (o_fn),
    .o_poc     (o_poc),
    .o_pn      (o_pn),
    .o_rtp     (o_rtp),
    .o_last    (m_tlast)
  );

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_accept && (s_tuser == REQ_SLICE || s_tuser == REQ_ACQUIRE || s_tuser == REQ_RELEASE)
    |=> !s_tready)
    else $error("input taken while a request is still in work");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ACQ || m_tuser == KIND_REL) |-> m_tlast)
    else $error("acquire or release answer without tlast");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_status != STAT_OK |-> m_tlast)
    else $error("error status on a word that is not the last");
`endif

endmodule

// ===== rtl/core/rfm_datapath.sv =====
// Datapath: slot pool, reference store, POC state, scan unit and output word register.
module rfm_datapath import rfm_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  parameter int MAX_REFS   = MAX_REFS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic [FN_W-1:0]      in_fn,
  input  logic                 in_idr,
  input  logic [1:0]           in_refidc,
  input  logic                 in_p,
  input  logic [RTP_W-1:0]     in_rtp,
  input  logic [SIDX_W-1:0]    in_sidx,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  dp_op_t               op,
  output dp_status_t           st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           o_kind,
  output logic [1:0]           o_status,
  output logic [SLOT_W-1:0]    o_slot,
  output logic [FN_W-1:0]      o_fn,
  output logic [POC_W-1:0]     o_poc,
  output logic [PN_W-1:0]      o_pn,
  output logic [RTP_W-1:0]     o_rtp,
  output logic                 o_last
);

  localparam int SW  = $clog2(POOL_SLOTS);
  localparam int RIW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int RCW = $clog2(MAX_REFS + 1);

  logic [CFG_W-1:0] lg_cfg, mr_cfg;

  logic [FN_W-1:0]   fn_q;
  logic              idr_q, p_q;
  logic [1:0]        refidc_q;
  logic [RTP_W-1:0]  rtp_q;
  logic [SIDX_W-1:0] sidx_q;

  logic [POOL_SLOTS-1:0] is_ref, lent;
  logic                  ready_valid;
  logic [SW-1:0]         ready_slot;
  logic [RTP_W-1:0]      stamp_mem [POOL_SLOTS];
  logic [RTP_W-1:0]      stamp_q;

  logic [SW-1:0]          ref_slot [MAX_REFS];
  logic [FN_W-1:0]        ref_fn   [MAX_REFS];
  logic signed [PN_W-1:0] ref_pn   [MAX_REFS];
  logic [POC_W-1:0]       ref_poc  [MAX_REFS];
  logic [RCW-1:0]         ref_count;
  logic [MAX_REFS-1:0]    used;

  logic [FN_W-1:0]  prev_fn;
  logic [POC_W-1:0] prev_off;
  logic [POC_W-1:0] poc_q;
  logic [SW-1:0]    slot_q;

  logic [RIW-1:0]         idx, best, k;
  logic                   have;
  logic signed [PN_W-1:0] best_pn;

  // clamped frame number modulus
  logic [4:0]       lg_c;
  logic [PN_W-1:0]  maxfn;
  logic [POC_W-1:0] off_c;
  logic [POOL_SLOTS-1:0] free_v;
  logic [SW-1:0]    free_slot;
  logic [RIW-1:0]   rd_idx;
  logic [CFG_W:0]   active;
  logic             cmp_hit;

  always_comb begin
    lg_c = lg_cfg;
    if (lg_cfg < 5'd4) lg_c = 5'd4;
    if (lg_cfg > 5'd16) lg_c = 5'd16;
    maxfn = PN_W'(1) << lg_c;
  end

  always_comb begin
    if (idr_q) off_c = '0;
    else if (prev_fn > fn_q) off_c = prev_off + POC_W'(maxfn);
    else off_c = prev_off;
  end

  always_comb begin
    free_slot = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      free_v[i] = !is_ref[i] && !lent[i] && !(ready_valid && ready_slot == SW'(i));
    end
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_v[i]) free_slot = SW'(i);
    end
  end

  always_comb begin
    active = {1'b0, mr_cfg};
    if (mr_cfg == '0) active = (CFG_W + 1)'(1);
    if ({1'b0, mr_cfg} > (CFG_W + 1)'(MAX_REFS)) active = (CFG_W + 1)'(MAX_REFS);
  end

  always_comb begin
    unique case (op)
      OP_LIST, OP_EVICT: rd_idx = best;
      default:           rd_idx = idx;
    endcase
  end

  // max search for list0 (strictly greater keeps store order), min for eviction
  always_comb begin
    if (op == OP_EVSCAN) cmp_hit = !have || (ref_pn[rd_idx] < best_pn);
    else cmp_hit = !used[rd_idx] && (!have || (ref_pn[rd_idx] > best_pn));
  end

  always_comb begin
    st.found      = |free_v;
    st.p_refs     = p_q && (ref_count != '0);
    st.scan_end   = (RCW'(idx) + RCW'(1)) == ref_count;
    st.list_end   = (RCW'(k) + RCW'(1)) == ref_count;
    st.ref_pic    = refidc_q != 2'd0;
    st.need_evict = ((CFG_W + 1)'(ref_count) >= active) && (ref_count != '0);
    st.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index == CFG_LOG2_MAX_FN) lg_cfg <= cfg_data;
    if (cfg_we && cfg_index == CFG_MAX_REFS) mr_cfg <= cfg_data;
    if (rst) begin
      lg_cfg <= CFG_W'(4);
      mr_cfg <= CFG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fn_q     <= in_fn;
      idr_q    <= in_idr;
      refidc_q <= in_refidc;
      p_q      <= in_p;
      rtp_q    <= in_rtp;
      sidx_q   <= in_sidx;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_FINISH) stamp_mem[slot_q] <= rtp_q;
    if (op == OP_ACQ_RD) stamp_q <= stamp_mem[ready_slot];
  end

  // reference store payload
  always_ff @(posedge clk) begin
    unique case (op)
      OP_PICNUM: begin
        for (int i = 0; i < MAX_REFS; i++) begin
          if (ref_fn[i] > fn_q) ref_pn[i] <= PN_W'({1'b0, ref_fn[i]}) - maxfn;
          else ref_pn[i] <= PN_W'({1'b0, ref_fn[i]});
        end
      end
      OP_EVICT: begin
        for (int i = 0; i + 1 < MAX_REFS; i++) begin
          if (RIW'(i) >= best && (RCW'(i) + RCW'(1)) < ref_count) begin
            ref_slot[i] <= ref_slot[i+1];
            ref_fn[i]   <= ref_fn[i+1];
            ref_pn[i]   <= ref_pn[i+1];
            ref_poc[i]  <= ref_poc[i+1];
          end
        end
      end
      OP_INSERT: begin
        if (ref_count < RCW'(MAX_REFS)) begin
          ref_slot[ref_count[RIW-1:0]] <= slot_q;
          ref_fn[ref_count[RIW-1:0]]   <= fn_q;
          ref_pn[ref_count[RIW-1:0]]   <= PN_W'({1'b0, fn_q});
          ref_poc[ref_count[RIW-1:0]]  <= poc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_ready) out_valid <= 1'b0;
    unique case (op)
      OP_POC: begin
        if (idr_q) begin
          is_ref    <= '0;
          ref_count <= '0;
        end
        poc_q    <= POC_W'((off_c + POC_W'(fn_q)) << 1) - POC_W'(refidc_q == 2'd0);
        prev_off <= off_c;
        prev_fn  <= fn_q;
      end
      OP_FIND: slot_q <= free_slot;
      OP_HDR: begin
        out_valid <= 1'b1;
        o_kind    <= KIND_SLICE;
        o_status  <= STAT_OK;
        o_slot    <= SLOT_W'(slot_q);
        o_fn      <= fn_q;
        o_poc     <= poc_q;
        o_pn      <= '0;
        o_rtp     <= '0;
        o_last    <= !(p_q && ref_count != '0);
        used      <= '0;
        k         <= '0;
        idx       <= '0;
        have      <= 1'b0;
      end
      OP_NOSLOT: begin
        out_valid <= 1'b1;
        o_kind    <= KIND_SLICE;
        o_status  <= STAT_NO_SLOT;
        o_slot    <= '0;
        o_fn      <= fn_q;
        o_poc     <= poc_q;
        o_pn      <= '0;
        o_rtp     <= '0;
        o_last    <= 1'b1;
      end
      OP_SCAN, OP_EVSCAN: begin
        if (cmp_hit) begin
          best    <= rd_idx;
          best_pn <= ref_pn[rd_idx];
          have    <= 1'b1;
        end
        idx <= idx + RIW'(1);
      end
      OP_LIST: begin
        out_valid  <= 1'b1;
        o_kind     <= KIND_LIST;
        o_status   <= STAT_OK;
        o_slot     <= SLOT_W'(ref_slot[rd_idx]);
        o_fn       <= ref_fn[rd_idx];
        o_poc      <= ref_poc[rd_idx];
        o_pn       <= ref_pn[rd_idx];
        o_rtp      <= '0;
        o_last     <= st.list_end;
        used[best] <= 1'b1;
        k          <= k + RIW'(1);
        idx        <= '0;
        have       <= 1'b0;
      end
      OP_FINISH: begin
        ready_slot  <= slot_q;
        ready_valid <= 1'b1;
        idx         <= '0;
        have        <= 1'b0;
      end
      OP_EVICT: begin
        is_ref[ref_slot[rd_idx]] <= 1'b0;
        ref_count <= ref_count - RCW'(1);
      end
      OP_INSERT: begin
        if (ref_count < RCW'(MAX_REFS)) begin
          is_ref[slot_q] <= 1'b1;
          ref_count      <= ref_count + RCW'(1);
        end
      end
      OP_ACQ: begin
        out_valid <= 1'b1;
        o_kind    <= KIND_ACQ;
        o_fn      <= '0;
        o_poc     <= '0;
        o_pn      <= '0;
        o_last    <= 1'b1;
        if (ready_valid) begin
          lent[ready_slot] <= 1'b1;
          ready_valid <= 1'b0;
          o_status    <= STAT_OK;
          o_slot      <= SLOT_W'(ready_slot);
          o_rtp       <= stamp_q;
        end else begin
          o_status <= STAT_NONE_READY;
          o_slot   <= '0;
          o_rtp    <= '0;
        end
      end
      OP_REL: begin
        out_valid <= 1'b1;
        o_kind    <= KIND_REL;
        o_fn      <= '0;
        o_poc     <= '0;
        o_pn      <= '0;
        o_rtp     <= '0;
        o_last    <= 1'b1;
        if ({1'b0, sidx_q} >= (SIDX_W + 1)'(POOL_SLOTS)) begin
          o_status <= STAT_BAD_INDEX;
          o_slot   <= '0;
        end else begin
          lent[sidx_q[SW-1:0]] <= 1'b0;
          o_status <= STAT_OK;
          o_slot   <= SLOT_W'(sidx_q);
        end
      end
      default: ;
    endcase
    if (rst) begin
      out_valid   <= 1'b0;
      is_ref      <= '0;
      lent        <= '0;
      ready_valid <= 1'b0;
      ready_slot  <= '0;
      ref_count   <= '0;
      prev_fn     <= '0;
      prev_off    <= '0;
    end
  end

endmodule

// ===== rtl/core/rfm_ctrl.sv =====
// Controller: sequences one request at a time through the datapath operations.
module rfm_ctrl import rfm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_accept,
  input  logic [1:0] in_req,
  input  dp_status_t st,
  output logic       in_ready,
  output dp_op_t     op
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_POC    = 14'b00000000000010,
    ST_FIND   = 14'b00000000000100,
    ST_NOSLOT = 14'b00000000001000,
    ST_PICNUM = 14'b00000000010000,
    ST_HDR    = 14'b00000000100000,
    ST_SCAN   = 14'b00000001000000,
    ST_LIST   = 14'b00000010000000,
    ST_FIN    = 14'b00000100000000,
    ST_EVSCAN = 14'b00001000000000,
    ST_EVICT  = 14'b00010000000000,
    ST_INSERT = 14'b00100000000000,
    ST_ACQ_RD = 14'b01000000000000,
    ST_REL    = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   acq_pend;

  assign in_ready = state == ST_IDLE && !acq_pend;

  always_comb begin
    state_next = state;
    op = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (acq_pend) begin
          if (st.out_free) op = OP_ACQ;
        end else if (in_accept) begin
          unique case (in_req)
            REQ_SLICE:   state_next = ST_POC;
            REQ_ACQUIRE: state_next = ST_ACQ_RD;
            REQ_RELEASE: state_next = ST_REL;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_POC: begin
        op = OP_POC;
        state_next = ST_FIND;
      end
      ST_FIND: begin
        op = OP_FIND;
        state_next = st.found ? ST_PICNUM : ST_NOSLOT;
      end
      ST_NOSLOT: begin
        if (st.out_free) begin
          op = OP_NOSLOT;
          state_next = ST_IDLE;
        end
      end
      ST_PICNUM: begin
        op = OP_PICNUM;
        state_next = ST_HDR;
      end
      ST_HDR: begin
        if (st.out_free) begin
          op = OP_HDR;
          state_next = st.p_refs ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        op = OP_SCAN;
        if (st.scan_end) state_next = ST_LIST;
      end
      ST_LIST: begin
        if (st.out_free) begin
          op = OP_LIST;
          state_next = st.list_end ? ST_FIN : ST_SCAN;
        end
      end
      ST_FIN: begin
        op = OP_FINISH;
        if (!st.ref_pic) state_next = ST_IDLE;
        else if (st.need_evict) state_next = ST_EVSCAN;
        else state_next = ST_INSERT;
      end
      ST_EVSCAN: begin
        op = OP_EVSCAN;
        if (st.scan_end) state_next = ST_EVICT;
      end
      ST_EVICT: begin
        op = OP_EVICT;
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        op = OP_INSERT;
        state_next = ST_IDLE;
      end
      ST_ACQ_RD: begin
        op = OP_ACQ_RD;
        state_next = ST_IDLE;
      end
      ST_REL: begin
        if (st.out_free) begin
          op = OP_REL;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // acquire answer waits in idle for the output register once the stamp is read
  always_ff @(posedge clk) begin
    state <= state_next;
    if (state == ST_ACQ_RD) acq_pend <= 1'b1;
    else if (op == OP_ACQ) acq_pend <= 1'b0;
    if (rst) begin
      state    <= ST_IDLE;
      acq_pend <= 1'b0;
    end
  end

endmodule
